### rtl/note_attack_hold_timer_macros.svh
// Assertion macros for the note attack/hold timer checker.
// Used by nah_checker only; no other dependencies.
`ifndef NOTE_ATTACK_HOLD_TIMER_MACROS_SVH
`define NOTE_ATTACK_HOLD_TIMER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define NAH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("note timer check failed");

// Consequent must hold in the same cycle as the antecedent ends.
`define NAH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("note timer check failed");

`endif

### rtl/nah_pkg.sv
// Shared types and constants for the note attack/hold timer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package nah_pkg;

    // Width of the note timer tick counter.
    localparam int COUNT_WIDTH = 8;

    // Coarse phase top: 0xff cut or extended to the counter width.
    localparam logic [COUNT_WIDTH-1:0] COARSE_TOP = COUNT_WIDTH'(32'hff);

    // Reset values.
    localparam logic [7:0] RST_PWM_DUTY     = 8'd127;
    localparam logic [7:0] RST_PWM_PERIOD   = 8'd254;
    localparam logic [7:0] RST_COARSE_VALUE = 8'd245;
    localparam logic [7:0] RST_FINE_VALUE   = 8'd25;
    localparam logic [1:0] RST_MODE_BITS    = 2'd1;

    // Mode bit positions.
    localparam int MODE_REPEAT_BIT = 0;
    localparam int MODE_PWM_BIT    = 1;

    // Timer phase codes.
    localparam logic PHASE_COARSE = 1'b0;
    localparam logic PHASE_FINE   = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_PWM_DUTY   = 1'b0;
    localparam logic CFG_PWM_PERIOD = 1'b1;

    // Argument counts.
    localparam logic [1:0] ARGS_NONE = 2'd0;
    localparam logic [1:0] ARGS_ONE  = 2'd1;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_SET_MODE = 2'd3
    } t_opcode;

    // One input beat as held in the input register.
    typedef struct packed {
        t_opcode    opcode;
        logic [1:0] arg_count;
        logic [7:0] coarse_arg;
        logic [7:0] fine_arg;
        logic [1:0] mode_arg;
        logic       timer_tick;
        logic       pwm_tick;
    } t_item;

    // Fine-period end events passed from the timer to the PWM unit.
    typedef struct packed {
        logic pwm_on;
        logic hold_on;
    } t_timer_evt;

endpackage

### rtl/nah_timer.sv
// Note timer: coarse/fine phase counter, mode bits and attack level.
// Depends on nah_pkg; feeds fine-period end events to nah_pwm.
`timescale 1ns / 1ps

module nah_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  nah_pkg::t_item      i_item,
    output logic                o_attack,
    output logic                o_active,
    output nah_pkg::t_timer_evt o_evt
);

    logic                            r_phase, n_phase;
    logic                            r_active, n_active;
    logic [nah_pkg::COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [7:0]                      r_cdone, n_cdone;
    logic [7:0]                      r_coarse, n_coarse;
    logic [7:0]                      r_fine, n_fine;
    logic [1:0]                      r_mode, n_mode;
    logic                            r_attack, n_attack;
    logic [nah_pkg::COUNT_WIDTH-1:0] top;
    logic [7:0]                      coarse_sel;

    // Top of the current phase.
    assign top = (r_phase == nah_pkg::PHASE_FINE) ?
                 nah_pkg::COUNT_WIDTH'(r_fine) : nah_pkg::COARSE_TOP;

    // Coarse value that a note-on restart sees.
    assign coarse_sel = (i_item.arg_count != nah_pkg::ARGS_NONE) ? i_item.coarse_arg : r_coarse;

    // Next state for one beat.
    always_comb begin
        n_phase  = r_phase;
        n_active = r_active;
        n_tick   = r_tick;
        n_cdone  = r_cdone;
        n_coarse = r_coarse;
        n_fine   = r_fine;
        n_mode   = r_mode;
        n_attack = r_attack;
        o_evt    = '0;
        if (i_en) begin
            case (i_item.opcode)
                nah_pkg::OP_TICK: begin
                    if (i_item.timer_tick && r_active) begin
                        if (r_tick != top) begin
                            n_tick = r_tick + nah_pkg::COUNT_WIDTH'(1);
                        end else begin
                            n_tick = '0;
                            if (r_phase == nah_pkg::PHASE_COARSE) begin
                                n_cdone = r_cdone + 8'd1;
                                if (n_cdone >= r_coarse) begin
                                    n_phase = nah_pkg::PHASE_FINE;
                                end
                            end else if (r_mode[nah_pkg::MODE_REPEAT_BIT]) begin
                                // Repeat: restart and toggle attack.
                                n_cdone      = '0;
                                n_phase      = (r_coarse != 8'd0) ? nah_pkg::PHASE_COARSE
                                                                  : nah_pkg::PHASE_FINE;
                                n_active     = 1'b1;
                                n_attack     = ~r_attack;
                                o_evt.pwm_on = 1'b1;
                            end else begin
                                // Single shot: drop attack, stop the timer, go to hold or PWM.
                                n_attack = 1'b0;
                                n_active = 1'b0;
                                if (r_mode[nah_pkg::MODE_PWM_BIT]) begin
                                    o_evt.pwm_on = 1'b1;
                                end else begin
                                    o_evt.hold_on = 1'b1;
                                end
                            end
                        end
                    end
                end
                nah_pkg::OP_NOTE_ON: begin
                    n_coarse = coarse_sel;
                    if (i_item.arg_count inside {2'd2, 2'd3}) begin
                        n_fine = i_item.fine_arg;
                    end
                    n_cdone  = '0;
                    n_tick   = '0;
                    n_attack = 1'b1;
                    n_active = 1'b1;
                    n_phase  = (coarse_sel != 8'd0) ? nah_pkg::PHASE_COARSE
                                                    : nah_pkg::PHASE_FINE;
                end
                nah_pkg::OP_NOTE_OFF: begin
                    n_active = 1'b0;
                end
                nah_pkg::OP_SET_MODE: begin
                    if (i_item.arg_count != nah_pkg::ARGS_NONE) begin
                        n_mode = i_item.mode_arg;
                        if (i_item.mode_arg[nah_pkg::MODE_REPEAT_BIT]) begin
                            n_cdone  = '0;
                            n_tick   = '0;
                            n_attack = 1'b1;
                            n_active = 1'b1;
                            n_phase  = (r_coarse != 8'd0) ? nah_pkg::PHASE_COARSE
                                                          : nah_pkg::PHASE_FINE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= nah_pkg::PHASE_COARSE;
            r_active <= 1'b1;
            r_tick   <= '0;
            r_cdone  <= '0;
            r_coarse <= nah_pkg::RST_COARSE_VALUE;
            r_fine   <= nah_pkg::RST_FINE_VALUE;
            r_mode   <= nah_pkg::RST_MODE_BITS;
            r_attack <= 1'b1;
        end else begin
            r_phase  <= n_phase;
            r_active <= n_active;
            r_tick   <= n_tick;
            r_cdone  <= n_cdone;
            r_coarse <= n_coarse;
            r_fine   <= n_fine;
            r_mode   <= n_mode;
            r_attack <= n_attack;
        end
    end

    assign o_attack = n_attack;
    assign o_active = n_active;

endmodule

### rtl/nah_pwm.sv
// PWM counter and hold output, with the duty and period registers.
// Depends on nah_pkg; takes fine-period end events from nah_timer.
`timescale 1ns / 1ps

module nah_pwm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  nah_pkg::t_item      i_item,
    input  nah_pkg::t_timer_evt i_evt,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output logic                o_hold,
    output logic                o_pwm_en
);

    logic       r_hold, n_hold;
    logic       r_pwm_en, n_pwm_en;
    logic [7:0] r_count, n_count;
    logic [7:0] r_duty;
    logic [7:0] r_period;
    logic       wrap;

    assign wrap = (r_count == r_period);

    // Next state for one beat; the timer event acts before the PWM tick.
    always_comb begin
        n_hold   = r_hold;
        n_pwm_en = r_pwm_en;
        n_count  = r_count;
        if (i_en) begin
            case (i_item.opcode)
                nah_pkg::OP_TICK: begin
                    if (i_evt.pwm_on) begin
                        n_pwm_en = 1'b1;
                    end
                    if (i_evt.hold_on) begin
                        n_hold = 1'b1;
                    end
                    if (i_item.pwm_tick) begin
                        n_count = wrap ? 8'd0 : r_count + 8'd1;
                        if (n_pwm_en) begin
                            if (wrap) begin
                                n_hold = 1'b1;
                            end
                            if (n_count == r_duty) begin
                                n_hold = 1'b0;
                            end
                        end
                    end
                end
                nah_pkg::OP_NOTE_OFF: begin
                    n_pwm_en = 1'b0;
                    n_hold   = 1'b0;
                end
                nah_pkg::OP_SET_MODE: begin
                    if (i_item.arg_count != nah_pkg::ARGS_NONE) begin
                        n_pwm_en = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= 1'b0;
            r_pwm_en <= 1'b0;
            r_count  <= '0;
        end else begin
            r_hold   <= n_hold;
            r_pwm_en <= n_pwm_en;
            r_count  <= n_count;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty   <= nah_pkg::RST_PWM_DUTY;
            r_period <= nah_pkg::RST_PWM_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nah_pkg::CFG_PWM_DUTY:   r_duty   <= i_cfg_data;
                nah_pkg::CFG_PWM_PERIOD: r_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_hold   = n_hold;
    assign o_pwm_en = n_pwm_en;

endmodule

### rtl/note_attack_hold_timer.sv
// Top level of the solenoid note driver: input register, timer, PWM, result register.
// Depends on nah_pkg, nah_timer and nah_pwm.
// A beat accepted into the input register moves on to the result register once that register is free.
// Throughput: one beat per cycle while the output is not stalled; state updates as a beat leaves the input register.
// The input register stalls only while a finished result waits in the result register.
// Reset (synchronous, active low) empties both registers and loads the power-up state.
`timescale 1ns / 1ps

module note_attack_hold_timer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [1:0] i_arg_count,
    input  logic [7:0] i_coarse_arg,
    input  logic [7:0] i_fine_arg,
    input  logic [1:0] i_mode_arg,
    input  logic       i_timer_tick,
    input  logic       i_pwm_tick,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_attack_out,
    output logic       o_hold_out,
    output logic       o_timer_running,
    output logic       o_pwm_running,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic                r_in_vld;
    nah_pkg::t_item      r_item;
    logic                r_out_vld;
    logic                r_attack, r_hold, r_active, r_pwm_en;
    logic                advance;
    logic                in_take;
    logic                n_attack, n_hold, n_active, n_pwm_en;
    nah_pkg::t_timer_evt evt;

    // Handshake control.
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= '{opcode:     nah_pkg::t_opcode'(i_opcode),
                        arg_count:  i_arg_count,
                        coarse_arg: i_coarse_arg,
                        fine_arg:   i_fine_arg,
                        mode_arg:   i_mode_arg,
                        timer_tick: i_timer_tick,
                        pwm_tick:   i_pwm_tick};
        end
    end

    nah_timer u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_item),
        .o_attack (n_attack),
        .o_active (n_active),
        .o_evt    (evt)
    );

    nah_pwm u_pwm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_item      (r_item),
        .i_evt       (evt),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_hold      (n_hold),
        .o_pwm_en    (n_pwm_en)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_attack <= n_attack;
            r_hold   <= n_hold;
            r_active <= n_active;
            r_pwm_en <= n_pwm_en;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_attack_out    = r_attack;
    assign o_hold_out      = r_hold;
    assign o_timer_running = r_active;
    assign o_pwm_running   = r_pwm_en;

endmodule

### rtl/nah_checker.sv
// Port-level checks for the note attack/hold timer, bound to the top level.
// Depends on nah_pkg and note_attack_hold_timer_macros.svh.
`timescale 1ns / 1ps
`include "note_attack_hold_timer_macros.svh"

module nah_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_opcode,
    input logic [1:0] i_arg_count,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_attack_out,
    input logic       o_hold_out,
    input logic       o_timer_running,
    input logic       o_pwm_running
);

    logic       in_beat;
    logic       out_wait;
    logic [3:0] out_bits;
    logic       note_off_in;
    logic       note_on_in;
    logic       set_mode_in;
    logic       note_off_seen;
    logic       note_on_seen;
    logic       pwm_off_seen;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_wait = o_out_valid && i_out_stall;
    assign out_bits = {o_attack_out, o_hold_out, o_timer_running, o_pwm_running};

    // Accepted command beats of interest.
    assign note_off_in = in_beat && (i_opcode == nah_pkg::OP_NOTE_OFF);
    assign note_on_in  = in_beat && (i_opcode == nah_pkg::OP_NOTE_ON);
    assign set_mode_in = in_beat && (i_opcode == nah_pkg::OP_SET_MODE) &&
                         (i_arg_count != nah_pkg::ARGS_NONE);

    // Result beats those commands must produce.
    assign note_off_seen = o_out_valid && !o_timer_running && !o_pwm_running && !o_hold_out;
    assign note_on_seen  = o_out_valid && o_attack_out && o_timer_running;
    assign pwm_off_seen  = o_out_valid && !o_pwm_running;

    // A stalled result beat holds.
    `NAH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(out_bits))

    // Reset empties the result register.
    `NAH_ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

    // A note-off shows a stopped timer with hold and PWM off.
    `NAH_ASSERT_NEXT(a_note_off, i_clk, i_rst_n, note_off_in ##1 !i_out_stall, note_off_seen)

    // A note-on shows attack high and the timer running.
    `NAH_ASSERT_NEXT(a_note_on, i_clk, i_rst_n, note_on_in ##1 !i_out_stall, note_on_seen)

    // A set-mode beat with an argument turns PWM off.
    `NAH_ASSERT_NEXT(a_set_mode, i_clk, i_rst_n, set_mode_in ##1 !i_out_stall, pwm_off_seen)

endmodule

bind note_attack_hold_timer nah_checker u_nah_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_opcode        (i_opcode),
    .i_arg_count     (i_arg_count),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_attack_out    (o_attack_out),
    .o_hold_out      (o_hold_out),
    .o_timer_running (o_timer_running),
    .o_pwm_running   (o_pwm_running)
);

### dv/note_attack_hold_timer_tb.sv
// Self-checking testbench for the solenoid note driver note_attack_hold_timer.
// Depends on nah_pkg and the RTL; it keeps its own prediction of the outputs
// and checks every result beat against it.
`timescale 1ns / 1ps

module note_attack_hold_timer_tb;
    import nah_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         MAX_REPORTS = 10;
    localparam logic [1:0] ARGS_BOTH   = 2'd2;
    localparam logic [1:0] ARGS_EXTRA  = 2'd3;

    typedef struct packed {
        logic attack;
        logic hold;
        logic timer_run;
        logic pwm_run;
    } t_drive_state;

    // DUT connections, all inputs known from time zero.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [1:0] i_opcode      = '0;
    logic [1:0] i_arg_count   = '0;
    logic [7:0] i_coarse_arg  = '0;
    logic [7:0] i_fine_arg    = '0;
    logic [1:0] i_mode_arg    = '0;
    logic       i_timer_tick  = 1'b0;
    logic       i_pwm_tick    = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic       i_cfg_index   = 1'b0;
    logic [7:0] i_cfg_data    = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_attack_out;
    logic       o_hold_out;
    logic       o_timer_running;
    logic       o_pwm_running;
    logic       o_cfg_ready;

    // Predicted driver state, starting at the power-up values.
    logic [7:0]             duty_reg    = RST_PWM_DUTY;
    logic [7:0]             period_reg  = RST_PWM_PERIOD;
    logic                   phase       = PHASE_COARSE;
    logic                   timer_on    = 1'b1;
    logic [COUNT_WIDTH-1:0] tick_cnt    = '0;
    logic [7:0]             coarse_done = 8'd0;
    logic [7:0]             note_coarse = RST_COARSE_VALUE;
    logic [7:0]             fine_val    = RST_FINE_VALUE;
    logic [1:0]             mode        = RST_MODE_BITS;
    logic                   attack      = 1'b1;
    logic                   hold        = 1'b0;
    logic                   pwm_on      = 1'b0;
    logic [7:0]             pwm_cnt     = 8'd0;

    t_drive_state expected_drive_q[$];
    int           fail_count    = 0;
    int           result_count  = 0;
    int           active_beats  = 0;
    int           cycle_count   = 0;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;

    note_attack_hold_timer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_arg_count     (i_arg_count),
        .i_coarse_arg    (i_coarse_arg),
        .i_fine_arg      (i_fine_arg),
        .i_mode_arg      (i_mode_arg),
        .i_timer_tick    (i_timer_tick),
        .i_pwm_tick      (i_pwm_tick),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_attack_out    (o_attack_out),
        .o_hold_out      (o_hold_out),
        .o_timer_running (o_timer_running),
        .o_pwm_running   (o_pwm_running),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // A note-on or a repeat restarts the timer from the top of its sequence.
    function automatic void restart_note_timer();
        coarse_done = 8'd0;
        tick_cnt    = '0;
        attack      = 1'b1;
        phase       = (note_coarse != 8'd0) ? PHASE_COARSE : PHASE_FINE;
        timer_on    = 1'b1;
    endfunction

    // Advances the predicted driver by one accepted beat and returns its outputs.
    function automatic t_drive_state apply_beat(t_item b);
        logic [COUNT_WIDTH-1:0] top;
        logic                   was_high;
        logic                   wrapped;
        case (b.opcode)
            OP_TICK: begin
                // The note timer acts before the PWM counter.
                if (b.timer_tick && timer_on) begin
                    top = (phase == PHASE_FINE) ? COUNT_WIDTH'(fine_val) : COARSE_TOP;
                    if (tick_cnt != top) begin
                        tick_cnt = tick_cnt + COUNT_WIDTH'(1);
                    end else begin
                        tick_cnt = '0;
                        if (phase == PHASE_COARSE) begin
                            coarse_done = coarse_done + 8'd1;
                            if (coarse_done >= note_coarse)
                                phase = PHASE_FINE;
                        end else if (mode[MODE_REPEAT_BIT]) begin
                            // Repeat mode toggles attack and forces PWM on.
                            was_high = attack;
                            restart_note_timer();
                            if (was_high)
                                attack = 1'b0;
                            pwm_on = 1'b1;
                        end else begin
                            attack = 1'b0;
                            if (mode[MODE_PWM_BIT])
                                pwm_on = 1'b1;
                            else
                                hold = 1'b1;
                            timer_on = 1'b0;
                        end
                    end
                end
                // The PWM counter runs free; the clear at duty wins over the wrap.
                if (b.pwm_tick) begin
                    wrapped = (pwm_cnt == period_reg);
                    pwm_cnt = wrapped ? 8'd0 : pwm_cnt + 8'd1;
                    if (pwm_on) begin
                        if (wrapped)
                            hold = 1'b1;
                        if (pwm_cnt == duty_reg)
                            hold = 1'b0;
                    end
                end
            end
            OP_NOTE_ON: begin
                if (b.arg_count != ARGS_NONE)
                    note_coarse = b.coarse_arg;
                if (b.arg_count > ARGS_ONE)
                    fine_val = b.fine_arg;
                restart_note_timer();
            end
            OP_NOTE_OFF: begin
                timer_on = 1'b0;
                pwm_on   = 1'b0;
                hold     = 1'b0;
            end
            OP_SET_MODE: begin
                if (b.arg_count != ARGS_NONE) begin
                    mode = b.mode_arg;
                    if (mode[MODE_REPEAT_BIT])
                        restart_note_timer();
                    pwm_on = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return '{attack, hold, timer_on, pwm_on};
    endfunction

    function automatic t_item make_beat(t_opcode op, logic [1:0] argn, logic [7:0] coarse,
                                        logic [7:0] fine, logic [1:0] md, logic tt,
                                        logic pt);
        t_item b;
        b.opcode     = op;
        b.arg_count  = argn;
        b.coarse_arg = coarse;
        b.fine_arg   = fine;
        b.mode_arg   = md;
        b.timer_tick = tt;
        b.pwm_tick   = pt;
        return b;
    endfunction

    function automatic t_item random_beat();
        t_item b;
        b.opcode     = t_opcode'($urandom_range(3));
        b.arg_count  = 2'($urandom_range(3));
        b.coarse_arg = 8'($urandom);
        b.fine_arg   = 8'($urandom);
        b.mode_arg   = 2'($urandom_range(3));
        b.timer_tick = 1'($urandom_range(1));
        b.pwm_tick   = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Sends one input beat, with a random gap in front of it, and records its outputs.
    task automatic send_beat(t_item b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= b.opcode;
        i_arg_count  <= b.arg_count;
        i_coarse_arg <= b.coarse_arg;
        i_fine_arg   <= b.fine_arg;
        i_mode_arg   <= b.mode_arg;
        i_timer_tick <= b.timer_tick;
        i_pwm_tick   <= b.pwm_tick;
        do @(posedge i_clk); while (o_in_stall);
        expected_drive_q.push_back(apply_beat(b));
        // Beats that leave the driver untouched do not count toward a goal.
        if (!(b.opcode == OP_TICK && !b.timer_tick && !b.pwm_tick) &&
            !(b.opcode == OP_SET_MODE && b.arg_count == ARGS_NONE))
            active_beats++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register writes happen only while the driver is idle.
    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PWM_DUTY)
            duty_reg = val;
        else
            period_reg = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result checker and random output stall.
    always @(posedge i_clk) begin : check_results
        t_drive_state want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (expected_drive_q.size() == 0) begin
                report_failure($sformatf("result %0d arrived with nothing expected",
                                         result_count));
            end else begin
                want = expected_drive_q.pop_front();
                if (o_attack_out !== want.attack || o_hold_out !== want.hold ||
                    o_timer_running !== want.timer_run || o_pwm_running !== want.pwm_run)
                    report_failure($sformatf(
                        "result %0d: expected attack=%b hold=%b timer=%b pwm=%b, got %b %b %b %b",
                        result_count, want.attack, want.hold, want.timer_run, want.pwm_run,
                        o_attack_out, o_hold_out, o_timer_running, o_pwm_running));
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Power-up state and register values before any command.
    task automatic test_power_up_state();
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b1));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b0, 1'b0));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b0));
    endtask

    // Every command, each argument count, and each way a fine period can end.
    task automatic test_command_set();
        send_beat(make_beat(OP_SET_MODE, ARGS_NONE, 8'd0, 8'd0, 2'd3, 1'b0, 1'b0));
        // Ticks riding on a command are ignored, as are absent arguments.
        send_beat(make_beat(OP_NOTE_ON, ARGS_NONE, 8'h55, 8'haa, 2'd3, 1'b1, 1'b1));
        send_beat(make_beat(OP_NOTE_ON, ARGS_ONE, 8'hff, 8'h00, 2'd0, 1'b0, 1'b0));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b0));
        // Three arguments behave as two; a zero coarse value starts in the fine phase.
        send_beat(make_beat(OP_NOTE_ON, ARGS_EXTRA, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b0));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b1));
        send_beat(make_beat(OP_NOTE_OFF, ARGS_EXTRA, 8'hff, 8'hff, 2'd3, 1'b1, 1'b1));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b0));
        // PWM hold without repeat: no restart, PWM starts at the fine end.
        send_beat(make_beat(OP_SET_MODE, ARGS_ONE, 8'd0, 8'd0, 2'd2, 1'b0, 1'b0));
        send_beat(make_beat(OP_NOTE_ON, ARGS_BOTH, 8'h00, 8'h01, 2'd0, 1'b0, 1'b0));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b0));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b0));
        // Steady hold at the fine end, then note-off clears it.
        send_beat(make_beat(OP_SET_MODE, ARGS_BOTH, 8'd0, 8'd0, 2'd0, 1'b0, 1'b0));
        send_beat(make_beat(OP_NOTE_ON, ARGS_BOTH, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b0));
        send_beat(make_beat(OP_NOTE_OFF, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b0, 1'b0));
        send_beat(make_beat(OP_SET_MODE, ARGS_ONE, 8'd0, 8'd0, 2'd3, 1'b0, 1'b0));
    endtask

    // Wrap and duty on the same count: the clear must win.
    task automatic test_pwm_coincidence();
        wait_drained();
        write_reg(CFG_PWM_DUTY, 8'd0);
        write_reg(CFG_PWM_PERIOD, 8'd0);
        send_beat(make_beat(OP_NOTE_ON, ARGS_BOTH, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b1, 1'b1));
        send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b0, 1'b1));
        wait_drained();
        write_reg(CFG_PWM_DUTY, 8'd1);
        write_reg(CFG_PWM_PERIOD, 8'd1);
        repeat (3)
            send_beat(make_beat(OP_TICK, ARGS_NONE, 8'd0, 8'd0, 2'd0, 1'b0, 1'b1));
    endtask

    // Mostly note-on followed by runs of ticks, with noise beats in between.
    task automatic test_random_traffic(int beat_goal, int snd_pct, int rcv_pct,
                                       logic [7:0] duty, logic [7:0] period);
        int    start;
        int    burst;
        int    pick;
        t_item b;
        wait_drained();
        send_idle_pct = snd_pct;
        stall_pct     = rcv_pct;
        write_reg(CFG_PWM_DUTY, duty);
        write_reg(CFG_PWM_PERIOD, period);
        start = active_beats;
        while (active_beats - start < beat_goal) begin
            if ($urandom_range(99) < 12) begin
                send_beat(random_beat());
            end else begin
                if ($urandom_range(99) < 30) begin
                    b           = random_beat();
                    b.opcode    = OP_SET_MODE;
                    b.arg_count = 2'($urandom_range(1, 3));
                    send_beat(b);
                end
                b           = random_beat();
                b.opcode    = OP_NOTE_ON;
                b.arg_count = ($urandom_range(99) < 80) ? ARGS_BOTH : 2'($urandom_range(3));
                // Short coarse values so that fine periods actually end.
                pick = $urandom_range(99);
                if (pick < 55)
                    b.coarse_arg = 8'd0;
                else if (pick < 80)
                    b.coarse_arg = 8'd1;
                else if (pick < 90)
                    b.coarse_arg = 8'd2;
                pick = $urandom_range(99);
                if (pick < 60)
                    b.fine_arg = 8'($urandom_range(7));
                else if (pick < 85)
                    b.fine_arg = 8'($urandom_range(8, 40));
                send_beat(b);
                burst = ($urandom_range(99) < 10) ? $urandom_range(260, 600)
                                                  : $urandom_range(3, 40);
                // A tick run stops early once the goal is met.
                for (int k = 0; k < burst && (active_beats - start) < beat_goal; k++) begin
                    b            = random_beat();
                    b.opcode     = OP_TICK;
                    b.timer_tick = ($urandom_range(99) < 90);
                    send_beat(b);
                end
                if ($urandom_range(99) < 15) begin
                    b        = random_beat();
                    b.opcode = OP_NOTE_OFF;
                    send_beat(b);
                end
            end
        end
    endtask

    initial begin
        send_idle_pct = 26;
        stall_pct     = 76;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up_state();
        test_command_set();
        test_pwm_coincidence();
        test_random_traffic(600, 26, 76, 8'd3, 8'd7);
        test_random_traffic(600, 76, 26, 8'd255, 8'd255);
        test_random_traffic(500, 0, 0, 8'($urandom_range(15)), 8'($urandom_range(15)));

        wait_drained();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
